>>> rtl/brsm_pkg.sv
// Shared constants, types and codes of the binding range set merge block.
`timescale 1ns / 1ps

package brsm_pkg;

  localparam int MAX_RANGES = 16;
  localparam int SLOT_BITS  = 16;
  localparam int IDX_BITS   = $clog2(MAX_RANGES);
  localparam int CNT_BITS   = $clog2(MAX_RANGES + 1);
  localparam int ENTRY_BITS = 2 * SLOT_BITS;

  typedef logic [SLOT_BITS-1:0] slot_t;
  typedef logic [IDX_BITS-1:0]  idx_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;

  localparam slot_t SLOT_TOP = '1;
  localparam idx_t  LAST_IDX = idx_t'(MAX_RANGES - 1);

  typedef enum logic [2:0] {
    STAT_NEW     = 3'd0,
    STAT_BELOW   = 3'd1,
    STAT_ABOVE   = 3'd2,
    STAT_FUSED   = 3'd3,
    STAT_OVERLAP = 3'd4,
    STAT_REJECT  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } state_t;

endpackage

>>> rtl/brsm_if.sv
// Valid/ready channel interfaces for range requests and insert results.
`timescale 1ns / 1ps

interface brsm_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] range_start;
  logic [15:0] range_end;

  modport source (output valid, output range_start, output range_end, input ready);
  modport sink   (input valid, input range_start, input range_end, output ready);
endinterface

interface brsm_out_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic [2:0] status;
  logic [4:0] range_count;

  modport source (output valid, output accepted, output status, output range_count,
                  input ready);
  modport sink   (input valid, input accepted, input status, input range_count,
                  output ready);
endinterface

>>> rtl/brsm_ram.sv
// Simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module brsm_ram #(
  parameter int DEPTH     = 16,
  parameter int WIDTH     = 32,
  parameter int ADDR_BITS = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/binding_range_set_merge.sv
// Top level: bounded set of disjoint slot ranges with insert and coalescing.
// A valid range walks every entry over the single read port of the entry RAM,
// then passes write-back and reply; a range with start above end goes straight
// to the reply. One insert at a time: a new range is taken only once the last
// one has been loaded into the result register.
// Reset (rst_n low, synchronous) clears every valid bit and the range count at
// once, so the table is empty on the first cycle after reset; no clearing pass.
`timescale 1ns / 1ps

module binding_range_set_merge (
  input  logic              clk,
  input  logic              rst_n,
  brsm_in_if.sink           in_chan,
  brsm_out_if.source        out_chan
);

  import brsm_pkg::*;

  // Request and walk state.
  state_t  state_r, state_nxt;
  slot_t   s_r, s_nxt;
  slot_t   e_r, e_nxt;
  idx_t    rd_addr_r, rd_addr_nxt;
  logic    issue_r, issue_nxt;
  logic    chk_v_r, chk_v_nxt;
  idx_t    chk_idx_r, chk_idx_nxt;

  // What the walk has found so far.
  logic    ovl_r, ovl_nxt;
  logic    below_v_r, below_v_nxt;
  idx_t    below_idx_r, below_idx_nxt;
  slot_t   below_first_r, below_first_nxt;
  logic    above_v_r, above_v_nxt;
  idx_t    above_idx_r, above_idx_nxt;
  slot_t   above_last_r, above_last_nxt;
  logic    free_v_r, free_v_nxt;
  idx_t    free_idx_r, free_idx_nxt;

  // Table bookkeeping held in flops; the range bounds live in the RAM.
  logic [MAX_RANGES-1:0] valid_r, valid_nxt;
  cnt_t    cnt_r, cnt_nxt;
  status_t stat_r, stat_nxt;

  // Result register.
  logic    out_valid_r, out_valid_nxt;
  logic    out_acc_r, out_acc_nxt;
  status_t out_stat_r, out_stat_nxt;
  logic [4:0] out_cnt_r, out_cnt_nxt;

  // RAM ports.
  logic                  ram_we;
  idx_t                  ram_waddr;
  logic [ENTRY_BITS-1:0] ram_wdata;
  logic [ENTRY_BITS-1:0] ram_rdata;
  slot_t                 rd_first;
  slot_t                 rd_last;

  logic    in_xfer;

  // Each RAM word holds one range: first slot in the upper half, last in the lower.
  brsm_ram #(
    .DEPTH (MAX_RANGES),
    .WIDTH (ENTRY_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr_r),
    .rdata (ram_rdata)
  );

  assign rd_first = ram_rdata[ENTRY_BITS-1:SLOT_BITS];
  assign rd_last  = ram_rdata[SLOT_BITS-1:0];

  // Requests are taken only between inserts. A finished result may still sit
  // in the output register while the next request is walked.
  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_xfer       = in_chan.valid && in_chan.ready;

  assign out_chan.valid       = out_valid_r;
  assign out_chan.accepted    = out_acc_r;
  assign out_chan.status      = out_stat_r;
  assign out_chan.range_count = out_cnt_r;

  always_comb begin
    state_nxt       = state_r;
    s_nxt           = s_r;
    e_nxt           = e_r;
    rd_addr_nxt     = rd_addr_r;
    issue_nxt       = 1'b0;
    chk_v_nxt       = issue_r;
    chk_idx_nxt     = rd_addr_r;
    ovl_nxt         = ovl_r;
    below_v_nxt     = below_v_r;
    below_idx_nxt   = below_idx_r;
    below_first_nxt = below_first_r;
    above_v_nxt     = above_v_r;
    above_idx_nxt   = above_idx_r;
    above_last_nxt  = above_last_r;
    free_v_nxt      = free_v_r;
    free_idx_nxt    = free_idx_r;
    valid_nxt       = valid_r;
    cnt_nxt         = cnt_r;
    stat_nxt        = stat_r;
    out_valid_nxt   = out_valid_r && !out_chan.ready;
    out_acc_nxt     = out_acc_r;
    out_stat_nxt    = out_stat_r;
    out_cnt_nxt     = out_cnt_r;
    ram_we          = 1'b0;
    ram_waddr       = '0;
    ram_wdata       = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          s_nxt       = slot_t'(in_chan.range_start);
          e_nxt       = slot_t'(in_chan.range_end);
          rd_addr_nxt = '0;
          ovl_nxt     = 1'b0;
          below_v_nxt = 1'b0;
          above_v_nxt = 1'b0;
          free_v_nxt  = 1'b0;
          // An inverted range skips the walk and leaves the table alone.
          if (slot_t'(in_chan.range_start) > slot_t'(in_chan.range_end)) begin
            stat_nxt  = STAT_REJECT;
            state_nxt = ST_DONE;
          end else begin
            issue_nxt = 1'b1;
            state_nxt = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // Address issue runs ahead of the data check: each entry is checked in the cycle after its address is issued.
        if (issue_r) begin
          if (rd_addr_r == LAST_IDX) begin
            issue_nxt = 1'b0;
          end else begin
            issue_nxt   = 1'b1;
            rd_addr_nxt = rd_addr_r + idx_t'(1);
          end
        end
        if (chk_v_r) begin
          if (valid_r[chk_idx_r]) begin
            if (s_r <= rd_last && e_r >= rd_first) begin
              ovl_nxt = 1'b1;
            end
            // Lowest-index neighbor wins; slot 0 and the top slot have no
            // neighbor beyond them.
            if (!below_v_r && s_r != '0 && rd_last == slot_t'(s_r - slot_t'(1))) begin
              below_v_nxt     = 1'b1;
              below_idx_nxt   = chk_idx_r;
              below_first_nxt = rd_first;
            end else if (!above_v_r && e_r != SLOT_TOP &&
                         rd_first == slot_t'(e_r + slot_t'(1))) begin
              above_v_nxt    = 1'b1;
              above_idx_nxt  = chk_idx_r;
              above_last_nxt = rd_last;
            end
          end else if (!free_v_r) begin
            free_v_nxt   = 1'b1;
            free_idx_nxt = chk_idx_r;
          end
          if (chk_idx_r == LAST_IDX) begin
            state_nxt = ST_WRITE;
          end
        end
      end

      ST_WRITE: begin
        state_nxt = ST_DONE;
        if (ovl_r) begin
          stat_nxt = STAT_OVERLAP;
        end else if (below_v_r && above_v_r) begin
          // Fuse: the lower entry grows to the end of the upper one, which is freed.
          ram_we                 = 1'b1;
          ram_waddr              = below_idx_r;
          ram_wdata              = {below_first_r, above_last_r};
          valid_nxt[above_idx_r] = 1'b0;
          if (cnt_r != '0) begin
            cnt_nxt = cnt_r - cnt_t'(1);
          end
          stat_nxt = STAT_FUSED;
        end else if (below_v_r) begin
          ram_we    = 1'b1;
          ram_waddr = below_idx_r;
          ram_wdata = {below_first_r, e_r};
          stat_nxt  = STAT_BELOW;
        end else if (above_v_r) begin
          ram_we    = 1'b1;
          ram_waddr = above_idx_r;
          ram_wdata = {s_r, above_last_r};
          stat_nxt  = STAT_ABOVE;
        end else if (free_v_r) begin
          ram_we                = 1'b1;
          ram_waddr             = free_idx_r;
          ram_wdata             = {s_r, e_r};
          valid_nxt[free_idx_r] = 1'b1;
          cnt_nxt               = cnt_r + cnt_t'(1);
          stat_nxt              = STAT_NEW;
        end else begin
          stat_nxt = STAT_REJECT;
        end
      end

      ST_DONE: begin
        // Load the result once the output register is free or being drained.
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_acc_nxt   = (stat_r == STAT_NEW) || (stat_r == STAT_BELOW) ||
                          (stat_r == STAT_ABOVE) || (stat_r == STAT_FUSED);
          out_stat_nxt  = stat_r;
          out_cnt_nxt   = 5'(cnt_r);
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issue_r     <= 1'b0;
      chk_v_r     <= 1'b0;
      valid_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issue_r     <= issue_nxt;
      chk_v_r     <= chk_v_nxt;
      valid_r     <= valid_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and walk results.
  always_ff @(posedge clk) begin
    s_r           <= s_nxt;
    e_r           <= e_nxt;
    rd_addr_r     <= rd_addr_nxt;
    chk_idx_r     <= chk_idx_nxt;
    ovl_r         <= ovl_nxt;
    below_v_r     <= below_v_nxt;
    below_idx_r   <= below_idx_nxt;
    below_first_r <= below_first_nxt;
    above_v_r     <= above_v_nxt;
    above_idx_r   <= above_idx_nxt;
    above_last_r  <= above_last_nxt;
    free_v_r      <= free_v_nxt;
    free_idx_r    <= free_idx_nxt;
    stat_r        <= stat_nxt;
    out_acc_r     <= out_acc_nxt;
    out_stat_r    <= out_stat_nxt;
    out_cnt_r     <= out_cnt_nxt;
  end

  // The count must always agree with the number of valid entries.
  assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(cnt_r))
    else $error("range count does not match valid entries");

  // A new result only appears after the reply step of an insert.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside the reply step");

  // The RAM is only written during write-back, and never for a rejected insert.
  assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_WRITE && !ovl_r))
    else $error("unexpected entry write");

  // The accepted flag agrees with the status code of the result.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_acc_r == (out_stat_r != STAT_OVERLAP && out_stat_r != STAT_REJECT)))
    else $error("accepted flag disagrees with status");

endmodule

>>> dv/tb_binding_range_set_merge.sv
// Self-checking testbench for the range set merge block: directed inserts, then random traffic.
`timescale 1ns / 1ps

module tb_binding_range_set_merge;
  import brsm_pkg::*;

  // Cycles with no transfer on either channel before the run is declared hung.
  // The slowest legal gap is roughly a long sender pause, the walk of one insert
  // and a long receiver stall, which stays well below this value.
  localparam int HANG_LIMIT = 4000;

  // Cycles to wait after the last reply.
  localparam int DRAIN_CYCLES = 2 * (MAX_RANGES + 4);

  localparam int SLOT_MAX = (1 << SLOT_BITS) - 1;

  // One reply as the block should produce it.
  typedef struct packed {
    logic    accepted;
    status_t status;
    cnt_t    count;
  } insert_reply_t;

  logic clk;
  logic rst_n;

  brsm_in_if  in_chan ();
  brsm_out_if out_chan ();

  binding_range_set_merge u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Shadow copy of the range table, updated at each accepted insert.
  slot_t tbl_first [MAX_RANGES];
  slot_t tbl_last  [MAX_RANGES];
  bit    tbl_valid [MAX_RANGES];
  cnt_t  tbl_count;

  // Replies still owed by the block, oldest first.
  insert_reply_t owed_replies [$];

  int sender_idle_pct = 0;
  int sink_stall_pct  = 0;
  int inserts_sent    = 0;
  int replies_checked = 0;
  int mismatches      = 0;
  int stall_cycles    = 0;
  int status_hist [6];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Works out the reply to one insert and applies it to the shadow table.
  // The scan stops at the first overlap, which takes priority over any merge.
  // A stored range that ends at start-1 is the lower neighbour and one that
  // begins at end+1 is the upper neighbour; slot 0 and the top slot have none.
  function automatic insert_reply_t predict_insert(slot_t s, slot_t e);
    int lo_idx;
    int hi_idx;
    bit hit;
    bit placed;
    status_t st;
    insert_reply_t r;
    lo_idx = -1;
    hi_idx = -1;
    hit    = 1'b0;
    placed = 1'b0;
    if (s > e) begin
      st = STAT_REJECT;
    end else begin
      for (int i = 0; i < MAX_RANGES; i++) begin
        if (!tbl_valid[i] || hit) continue;
        if (s <= tbl_last[i] && e >= tbl_first[i]) begin
          hit = 1'b1;
        end else if (lo_idx < 0 && s != '0 && tbl_last[i] == slot_t'(s - 1'b1)) begin
          lo_idx = i;
        end else if (hi_idx < 0 && e != SLOT_TOP && tbl_first[i] == slot_t'(e + 1'b1)) begin
          hi_idx = i;
        end
      end
      if (hit) begin
        st = STAT_OVERLAP;
      end else if (lo_idx >= 0 && hi_idx >= 0) begin
        // Both neighbours: the lower entry absorbs the upper one, which is freed.
        tbl_last[lo_idx]  = tbl_last[hi_idx];
        tbl_valid[hi_idx] = 1'b0;
        tbl_first[hi_idx] = '0;
        tbl_last[hi_idx]  = '0;
        if (tbl_count != '0) tbl_count = tbl_count - 1'b1;
        st = STAT_FUSED;
      end else if (lo_idx >= 0) begin
        tbl_last[lo_idx] = e;
        st = STAT_BELOW;
      end else if (hi_idx >= 0) begin
        tbl_first[hi_idx] = s;
        st = STAT_ABOVE;
      end else begin
        // Isolated range: lowest free entry, or rejected when the table is full.
        for (int i = 0; i < MAX_RANGES; i++) begin
          if (!placed && !tbl_valid[i]) begin
            tbl_valid[i] = 1'b1;
            tbl_first[i] = s;
            tbl_last[i]  = e;
            tbl_count    = tbl_count + 1'b1;
            placed       = 1'b1;
          end
        end
        st = placed ? STAT_NEW : STAT_REJECT;
      end
    end
    r.accepted = (st <= STAT_FUSED);
    r.status   = st;
    r.count    = tbl_count;
    return r;
  endfunction

  // Returns a random stored entry, or -1 when the table is empty.
  function automatic int pick_entry();
    int base;
    int idx;
    base = $urandom_range(MAX_RANGES - 1);
    for (int k = 0; k < MAX_RANGES; k++) begin
      idx = (base + k) % MAX_RANGES;
      if (tbl_valid[idx]) return idx;
    end
    return -1;
  endfunction

  // Offers one insert, with an optional random pause first. Valid is only
  // lowered during a pause, so back-to-back transfers keep it high. The
  // transfer is recognized at the edge where valid and ready were both high.
  task automatic send_range(input int s, input int e);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.range_start <= slot_t'(s);
    in_chan.range_end   <= slot_t'(e);
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    owed_replies.push_back(predict_insert(slot_t'(s), slot_t'(e)));
    inserts_sent++;
  endtask

  // Start above end is refused without touching the table.
  task automatic test_bad_ranges();
    send_range(1, 0);
    send_range(SLOT_MAX, 0);
  endtask

  // Both ends of the slot space, merges on each side and a fuse of two entries.
  task automatic test_edges_and_merges();
    send_range(0, 0);
    send_range(SLOT_MAX, SLOT_MAX);
    send_range(1, 5);                      // joins [0,0] from above
    send_range(SLOT_MAX - 15, SLOT_MAX - 1); // joins the top slot from below
    send_range(100, 200);
    send_range(6, 99);                     // bridges [0,5] and [100,200]
  endtask

  // A range inside a stored one, a range that wholly contains a stored one, and the full space.
  task automatic test_overlap();
    send_range(3, 3);
    send_range(250, 260);
    send_range(240, 270);
    send_range(0, SLOT_MAX);
  endtask

  // Fills every entry with small ranges ten slots apart, hits the full-table
  // refusal, then shows that a fuse still works while the table is full.
  task automatic test_table_full();
    for (int k = 0; k < MAX_RANGES - 3; k++) send_range(1000 + 20 * k, 1009 + 20 * k);
    send_range(30000, 30000);
    send_range(1010, 1019);
  endtask

  // Random inserts. Most grow a stored range toward its neighbour, sometimes
  // closing the gap exactly so that the two fuse; the rest are isolated new
  // ranges, overlaps and containing ranges, fully random ranges and bad ranges.
  task automatic test_random_traffic(input int send_pct, input int stall_pct, input int n);
    int kind;
    int j;
    int lo;
    int hi;
    int len;
    int gap;
    int nb;
    int tmp;
    sender_idle_pct = send_pct;
    sink_stall_pct  = stall_pct;
    for (int n_done = 0; n_done < n; n_done++) begin
      kind = $urandom_range(99);
      j    = pick_entry();
      if (kind < 10) begin
        lo = $urandom_range(SLOT_MAX, 1);
        hi = $urandom_range(lo - 1, 0);
        tmp = lo;
        lo = hi;
        hi = tmp;
        send_range(hi, lo);
      end else begin
        if (kind < 20) begin
          lo = $urandom_range(SLOT_MAX);
          hi = $urandom_range(SLOT_MAX);
          if (lo > hi) begin
            tmp = lo;
            lo = hi;
            hi = tmp;
          end
        end else if (kind < 35 || j < 0) begin
          if (j >= 0 && $urandom_range(1)) lo = int'(tbl_last[j]) + 2 + $urandom_range(20);
          else lo = $urandom_range(SLOT_MAX);
          if (lo > SLOT_MAX) lo = SLOT_MAX;
          hi = lo + $urandom_range(15);
          if (hi > SLOT_MAX) hi = SLOT_MAX;
        end else if (kind < 45) begin
          lo = int'(tbl_first[j]) - int'($urandom_range(4));
          hi = int'(tbl_last[j]) + int'($urandom_range(4));
          if (lo < 0) lo = 0;
          if (hi > SLOT_MAX) hi = SLOT_MAX;
        end else if ($urandom_range(1)) begin
          // Grow upward from entry j toward the next stored range.
          lo = int'(tbl_last[j]) + 1;
          nb = SLOT_MAX + 1;
          for (int i = 0; i < MAX_RANGES; i++) begin
            if (tbl_valid[i] && tbl_first[i] > tbl_last[j] && int'(tbl_first[i]) < nb)
              nb = int'(tbl_first[i]);
          end
          gap = nb - lo;
          if (gap <= 0) begin
            lo = int'(tbl_last[j]);
            hi = lo;
          end else begin
            len = (gap <= 40 && $urandom_range(1)) ? gap : $urandom_range(gap < 8 ? gap : 8, 1);
            hi  = lo + len - 1;
          end
        end else begin
          // Grow downward from entry j toward the previous stored range.
          hi = int'(tbl_first[j]) - 1;
          nb = -1;
          for (int i = 0; i < MAX_RANGES; i++) begin
            if (tbl_valid[i] && tbl_last[i] < tbl_first[j] && int'(tbl_last[i]) > nb)
              nb = int'(tbl_last[i]);
          end
          gap = hi - nb;
          if (gap <= 0) begin
            lo = int'(tbl_first[j]);
            hi = lo;
          end else begin
            len = (gap <= 40 && $urandom_range(1)) ? gap : $urandom_range(gap < 8 ? gap : 8, 1);
            lo  = hi - len + 1;
          end
        end
        send_range(lo, hi);
      end
    end
  endtask

  // Receiver side: ready is redrawn every cycle from the current stall rate.
  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_chan.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Compares every reply with the oldest owed one, field by field.
  always @(posedge clk) begin
    insert_reply_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (owed_replies.size() == 0) begin
        $error("reply with no insert pending: accepted %0d status %0d count %0d",
               out_chan.accepted, out_chan.status, out_chan.range_count);
        mismatches++;
      end else begin
        want = owed_replies.pop_front();
        if (out_chan.accepted !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, out_chan.accepted);
          mismatches++;
        end
        if (out_chan.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_chan.status);
          mismatches++;
        end
        if (out_chan.range_count !== want.count) begin
          $error("range_count: expected %0d, got %0d", want.count, out_chan.range_count);
          mismatches++;
        end
        replies_checked++;
        if (want.status <= STAT_REJECT) status_hist[want.status]++;
      end
    end
  end

  // Hang detection: counts cycles in which neither channel completes a transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= HANG_LIMIT) begin
      $display("timeout after %0d cycles without a transfer", HANG_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_n               <= 1'b0;
    in_chan.valid       <= 1'b0;
    in_chan.range_start <= '0;
    in_chan.range_end   <= '0;
    for (int i = 0; i < MAX_RANGES; i++) begin
      tbl_first[i] = '0;
      tbl_last[i]  = '0;
      tbl_valid[i] = 1'b0;
    end
    tbl_count = '0;
    foreach (status_hist[i]) status_hist[i] = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_bad_ranges();
    test_edges_and_merges();
    test_overlap();
    test_table_full();
    test_random_traffic(0, 0, 250);
    test_random_traffic(75, 0, 250);
    test_random_traffic(0, 75, 250);
    test_random_traffic(18, 18, 250);
    in_chan.valid <= 1'b0;

    // Drain: every owed reply must arrive, then a quiet tail catches extras.
    while (owed_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d inserts sent under four idle/stall mixes, %0d replies checked", inserts_sent,
             replies_checked);
    $display("new %0d, below %0d, above %0d, fused %0d, overlap %0d, full or bad %0d",
             status_hist[STAT_NEW], status_hist[STAT_BELOW], status_hist[STAT_ABOVE],
             status_hist[STAT_FUSED], status_hist[STAT_OVERLAP], status_hist[STAT_REJECT]);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/brsm_pkg.sv
rtl/brsm_if.sv
rtl/brsm_ram.sv
rtl/binding_range_set_merge.sv
dv/tb_binding_range_set_merge.sv
